// ===== design/esd_pkg.sv =====
`timescale 1ns / 1ps

package esd_pkg;

    localparam int unsigned REQ_W    = 2;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned PROD_W   = 2 * WORD_W;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned DIST_W   = PROD_W - FRAC_W;

    localparam int unsigned NUM_REQUESTERS_DEFAULT = 4;

    localparam logic [WORD_W-1:0] RPM_FACTOR_RESET         = 32'd7000000;
    localparam logic [WORD_W-1:0] CABLE_SPEED_FACTOR_RESET = 32'd58866392;
    localparam logic [WORD_W-1:0] DISTANCE_FACTOR_RESET    = 32'd4905540;
    localparam logic [WORD_W-1:0] ZERO_OFFSET_RESET        = 32'd0;

    typedef enum logic [1:0] {
        REG_RPM_FACTOR,
        REG_CABLE_SPEED_FACTOR,
        REG_DISTANCE_FACTOR,
        REG_ZERO_OFFSET
    } cfg_reg_t;

endpackage

// ===== design/esd_sample_if.sv =====
`timescale 1ns / 1ps

interface esd_sample_if;
    logic                            valid;
    logic                            ready;
    logic [esd_pkg::REQ_W-1:0]       requester;
    logic [esd_pkg::WORD_W-1:0]      capture_time;
    logic [esd_pkg::WORD_W-1:0]      encoder_count;

    modport source (output valid, requester, capture_time, encoder_count, input ready);
    modport sink   (input valid, requester, capture_time, encoder_count, output ready);
endinterface

// ===== design/esd_result_if.sv =====
`timescale 1ns / 1ps

interface esd_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [esd_pkg::WORD_W-1:0] speed_rpm;
    logic signed [esd_pkg::WORD_W-1:0] cable_speed;
    logic signed [esd_pkg::WORD_W-1:0] cable_distance;
    logic                              no_motion;
    logic                              div_error;

    modport source (output valid, speed_rpm, cable_speed, cable_distance, no_motion,
                    div_error, input ready);
    modport sink   (input valid, speed_rpm, cable_speed, cable_distance, no_motion,
                    div_error, output ready);
endinterface

// ===== design/esd_cfg_if.sv =====
`timescale 1ns / 1ps

interface esd_cfg_if;
    logic                        valid;
    logic                        ready;
    esd_pkg::cfg_reg_t           index;
    logic [esd_pkg::WORD_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/esd_mul.sv =====
`timescale 1ns / 1ps

module esd_mul
(
    input  logic                         clk,
    input  logic [esd_pkg::WORD_W-1:0]   a,
    input  logic [esd_pkg::WORD_W-1:0]   b,
    output logic [esd_pkg::PROD_W-1:0]   p
);

    logic [esd_pkg::PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= {{esd_pkg::WORD_W{1'b0}}, a} * {{esd_pkg::WORD_W{1'b0}}, b};
    end

    assign p = p_reg;

endmodule

// ===== design/esd_div.sv =====
`timescale 1ns / 1ps

// Restoring divider: quotient = floor({num_hi, num_lo, 16'b0} / den), clamped to all ones.
module esd_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [esd_pkg::DIST_W-1:0]    num_hi,
    input  logic [esd_pkg::FRAC_W-1:0]    num_lo,
    input  logic [esd_pkg::WORD_W-1:0]    den,
    output logic                          done,
    output logic [esd_pkg::WORD_W-1:0]    quot
);

    localparam int unsigned STEP_W = $clog2(esd_pkg::WORD_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(esd_pkg::WORD_W - 1);

    logic                         busy_reg;
    logic                         done_reg;
    logic [STEP_W-1:0]            step_reg;
    logic [esd_pkg::WORD_W-1:0]   rem_reg;
    logic [esd_pkg::WORD_W-1:0]   lo_reg;

    logic                         overflow;
    logic [esd_pkg::WORD_W:0]     trial;
    logic                         fits;
    logic [esd_pkg::WORD_W:0]     diff;

    // Quotient does not fit 32 bits when the upper dividend bits reach the divisor.
    assign overflow = (num_hi >= {{(esd_pkg::DIST_W-esd_pkg::WORD_W){1'b0}}, den});
    assign trial    = {rem_reg, lo_reg[esd_pkg::WORD_W-1]};
    assign fits     = (trial >= {1'b0, den});
    assign diff     = trial - {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= '0;
                if (overflow)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            if (overflow)
            begin
                lo_reg <= '1;
            end
            else
            begin
                rem_reg <= num_hi[esd_pkg::WORD_W-1:0];
                lo_reg  <= {num_lo, {(esd_pkg::WORD_W-esd_pkg::FRAC_W){1'b0}}};
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[esd_pkg::WORD_W-1:0] : trial[esd_pkg::WORD_W-1:0];
            lo_reg  <= {lo_reg[esd_pkg::WORD_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = lo_reg;

endmodule

// ===== design/encoder_speed_and_distance.sv =====
`timescale 1ns / 1ps

// Encoder speed and cable distance per requester channel.
// samples: one word per encoder sample (requester, capture_time, encoder_count).
//   ready is high only while the block is idle; a word is taken when valid and
//   ready are both high.
// results: one word per sample (speed_rpm, cable_speed, cable_distance in Q16.16,
//   no_motion, div_error), held in an output register until taken.
// cfg: register writes, always ready; write only while no sample is in flight.
// Sequence: a moving sample passes through the 32-step serial divider and makes
//   three passes through the shared 32x32 multiplier; when the quotient overflows
//   or the tick gap is zero the divider skips its steps and returns all ones; a
//   sample with no count change goes from ST_LOAD straight to the output.
// Acceptance: the next sample is accepted the cycle after the result is loaded
//   into the output register, even while that result stalls.
// If the receiver holds results.ready low with a result pending, the block waits
//   before loading the following result and stays not ready meanwhile.
// Reset clears the previous samples of every channel, the last distance and the
//   pending result, and restores the register defaults.
module encoder_speed_and_distance
#(
    parameter int unsigned NUM_REQUESTERS = esd_pkg::NUM_REQUESTERS_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    esd_sample_if.sink   samples,
    esd_result_if.source results,
    esd_cfg_if.sink      cfg
);

    localparam int unsigned CH_W = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
    localparam int unsigned W    = esd_pkg::WORD_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL_RPM,
        ST_MUL_DIST,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL_CAB,
        ST_CAB,
        ST_OUTPUT
    } state_t;

    function automatic logic [CH_W-1:0] channel_of(input logic [esd_pkg::REQ_W-1:0] r);
        logic [4:0] v;
        v = {3'b000, r};
        for (int i = 0; i < 3; i++)
        begin
            if (v >= 5'(NUM_REQUESTERS))
            begin
                v = v - 5'(NUM_REQUESTERS);
            end
        end
        return CH_W'(v);
    endfunction

    function automatic logic [W-1:0] sat(input logic [esd_pkg::DIST_W-1:0] mag,
                                         input logic neg);
        logic [W-1:0] res;
        if (neg)
        begin
            if (mag >= esd_pkg::DIST_W'(33'h080000000))
                res = {1'b1, {(W-1){1'b0}}};
            else
                res = '0 - mag[W-1:0];
        end
        else
        begin
            if (mag > esd_pkg::DIST_W'(33'h07FFFFFFF))
                res = {1'b0, {(W-1){1'b1}}};
            else
                res = mag[W-1:0];
        end
        return res;
    endfunction

    state_t                       state_reg;

    logic [W-1:0]                 rpm_factor_reg;
    logic [W-1:0]                 cable_speed_factor_reg;
    logic [W-1:0]                 distance_factor_reg;
    logic signed [W-1:0]          zero_offset_reg;

    logic [W-1:0]                 prev_time_reg  [NUM_REQUESTERS];
    logic [W-1:0]                 prev_count_reg [NUM_REQUESTERS];
    logic [W-1:0]                 last_distance_reg;

    logic [CH_W-1:0]              ch_reg;
    logic [W-1:0]                 time_reg;
    logic [W-1:0]                 count_reg;
    logic                         neg_reg;
    logic                         netneg_reg;
    logic                         derr_reg;
    logic [W-1:0]                 cmag_reg;
    logic [W-1:0]                 netmag_reg;
    logic [W-1:0]                 dtim_reg;
    logic [esd_pkg::PROD_W-1:0]   num_reg;
    logic [esd_pkg::DIST_W-1:0]   dist_reg;
    logic [W-1:0]                 m_reg;

    logic [W-1:0]                 res_speed_reg;
    logic [W-1:0]                 res_cable_reg;
    logic [W-1:0]                 res_dist_reg;
    logic                         res_nm_reg;
    logic                         res_de_reg;

    logic                         out_valid_reg;
    logic [W-1:0]                 out_speed_reg;
    logic [W-1:0]                 out_cable_reg;
    logic [W-1:0]                 out_dist_reg;
    logic                         out_nm_reg;
    logic                         out_de_reg;

    logic [W-1:0]                 dcnt;
    logic [W-1:0]                 dtim;
    logic [W-1:0]                 net;
    logic [W-1:0]                 mul_a;
    logic [W-1:0]                 mul_b;
    logic [esd_pkg::PROD_W-1:0]   mul_p;
    logic                         div_start;
    logic                         div_done;
    logic [W-1:0]                 div_quot;
    logic                         out_free;

    assign dcnt     = count_reg - prev_count_reg[ch_reg];
    assign dtim     = time_reg - prev_time_reg[ch_reg];
    assign net      = $unsigned(zero_offset_reg) + count_reg;
    assign out_free = !out_valid_reg || results.ready;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_RPM:
            begin
                mul_a = rpm_factor_reg;
                mul_b = cmag_reg;
            end
            ST_MUL_DIST:
            begin
                mul_a = netmag_reg;
                mul_b = distance_factor_reg;
            end
            ST_MUL_CAB:
            begin
                mul_a = m_reg;
                mul_b = cable_speed_factor_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign div_start = (state_reg == ST_DIV_START);

    esd_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    esd_div u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num_hi (num_reg[esd_pkg::PROD_W-1:esd_pkg::FRAC_W]),
        .num_lo (num_reg[esd_pkg::FRAC_W-1:0]),
        .den    (dtim_reg),
        .done   (div_done),
        .quot   (div_quot)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpm_factor_reg         <= esd_pkg::RPM_FACTOR_RESET;
            cable_speed_factor_reg <= esd_pkg::CABLE_SPEED_FACTOR_RESET;
            distance_factor_reg    <= esd_pkg::DISTANCE_FACTOR_RESET;
            zero_offset_reg        <= $signed(esd_pkg::ZERO_OFFSET_RESET);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                esd_pkg::REG_RPM_FACTOR:         rpm_factor_reg         <= cfg.data;
                esd_pkg::REG_CABLE_SPEED_FACTOR: cable_speed_factor_reg <= cfg.data;
                esd_pkg::REG_DISTANCE_FACTOR:    distance_factor_reg    <= cfg.data;
                esd_pkg::REG_ZERO_OFFSET:        zero_offset_reg        <= $signed(cfg.data);
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // Sequencer, channel state and registered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
            last_distance_reg <= '0;
            for (int i = 0; i < NUM_REQUESTERS; i++)
            begin
                prev_time_reg[i]  <= '0;
                prev_count_reg[i] <= '0;
            end
        end
        else
        begin
            // the output state reloads the register itself when it is taken
            if (out_valid_reg && results.ready && (state_reg != ST_OUTPUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (samples.valid)
                    begin
                        ch_reg    <= channel_of(samples.requester);
                        time_reg  <= samples.capture_time;
                        count_reg <= samples.encoder_count;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    if (dcnt == '0)
                    begin
                        res_speed_reg <= '0;
                        res_cable_reg <= '0;
                        res_dist_reg  <= last_distance_reg;
                        res_nm_reg    <= 1'b1;
                        res_de_reg    <= 1'b0;
                        state_reg     <= ST_OUTPUT;
                    end
                    else
                    begin
                        prev_time_reg[ch_reg]  <= time_reg;
                        prev_count_reg[ch_reg] <= count_reg;
                        neg_reg    <= dcnt[W-1];
                        cmag_reg   <= dcnt[W-1] ? ('0 - dcnt) : dcnt;
                        dtim_reg   <= dtim;
                        derr_reg   <= (dtim == '0);
                        netneg_reg <= net[W-1];
                        netmag_reg <= net[W-1] ? ('0 - net) : net;
                        state_reg  <= ST_MUL_RPM;
                    end
                end
                ST_MUL_RPM:
                begin
                    state_reg <= ST_MUL_DIST;
                end
                ST_MUL_DIST:
                begin
                    num_reg   <= mul_p;
                    state_reg <= ST_DIV_START;
                end
                ST_DIV_START:
                begin
                    dist_reg  <= mul_p[esd_pkg::PROD_W-1:esd_pkg::FRAC_W];
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        m_reg     <= div_quot;
                        state_reg <= ST_MUL_CAB;
                    end
                end
                ST_MUL_CAB:
                begin
                    state_reg <= ST_CAB;
                end
                ST_CAB:
                begin
                    res_speed_reg <= sat({{(esd_pkg::DIST_W-W){1'b0}}, m_reg}, neg_reg);
                    res_cable_reg <= sat({{(esd_pkg::DIST_W-W){1'b0}},
                                          mul_p[esd_pkg::PROD_W-1:W]}, neg_reg);
                    res_dist_reg  <= sat(dist_reg, netneg_reg);
                    last_distance_reg <= sat(dist_reg, netneg_reg);
                    res_nm_reg    <= 1'b0;
                    res_de_reg    <= derr_reg;
                    state_reg     <= ST_OUTPUT;
                end
                ST_OUTPUT:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_speed_reg <= res_speed_reg;
                        out_cable_reg <= res_cable_reg;
                        out_dist_reg  <= res_dist_reg;
                        out_nm_reg    <= res_nm_reg;
                        out_de_reg    <= res_de_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign samples.ready          = (state_reg == ST_IDLE);
    assign results.valid          = out_valid_reg;
    assign results.speed_rpm      = $signed(out_speed_reg);
    assign results.cable_speed    = $signed(out_cable_reg);
    assign results.cable_distance = $signed(out_dist_reg);
    assign results.no_motion      = out_nm_reg;
    assign results.div_error      = out_de_reg;

endmodule

// ===== test/esd_checker.sv =====
`timescale 1ns / 1ps

module esd_checker
(
    input  logic        clk,
    input  logic        rst_n,
    esd_sample_if       samples,
    esd_result_if       results,
    esd_cfg_if          cfg,
    output int unsigned mismatches,
    output int unsigned pending,
    output int unsigned results_seen
);

    localparam int unsigned CHANNELS = esd_pkg::NUM_REQUESTERS_DEFAULT;
    localparam int unsigned MAX_PRINTED = 30;

    typedef struct packed {
        logic [31:0] speed_rpm;
        logic [31:0] cable_speed;
        logic [31:0] cable_distance;
        logic        no_motion;
        logic        div_error;
    } speed_word_t;

    logic [31:0] rpm_scale;
    logic [31:0] cable_scale;
    logic [31:0] dist_scale;
    logic [31:0] count_offset;

    logic [31:0] chan_time  [CHANNELS];
    logic [31:0] chan_count [CHANNELS];
    logic [31:0] held_distance;

    speed_word_t speed_words_due[$];
    speed_word_t want;

    function automatic logic [31:0] clamp_signed(input logic [63:0] mag, input logic neg);
        if (neg)
            return (mag >= 64'h8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic speed_word_t predict_speed(input logic [esd_pkg::REQ_W-1:0] req,
                                                  input logic [31:0] tim,
                                                  input logic [31:0] cnt);
        int unsigned ch;
        logic [31:0] dcnt;
        logic [31:0] dtim;
        logic [31:0] net;
        logic [31:0] net_mag;
        logic        neg;
        logic        net_neg;
        logic [63:0] cnt_mag;
        logic [63:0] num;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] rpm_mag;
        logic [63:0] cab_mag;
        logic [63:0] dist_mag;
        speed_word_t w;
        ch = req % CHANNELS;
        dcnt = cnt - chan_count[ch];
        w = '0;
        // no count change: zero speeds, keep the channel sample, repeat distance
        if (dcnt == 32'd0)
        begin
            w.cable_distance = held_distance;
            w.no_motion = 1'b1;
            return w;
        end
        dtim = tim - chan_time[ch];
        chan_time[ch] = tim;
        chan_count[ch] = cnt;
        neg = dcnt[31];
        cnt_mag = {32'd0, neg ? (~dcnt + 32'd1) : dcnt};
        if (dtim == 32'd0)
        begin
            w.div_error = 1'b1;
            rpm_mag = 64'hFFFF_FFFF;
        end
        else
        begin
            num = {32'd0, rpm_scale} * cnt_mag;
            quo = num / {32'd0, dtim};
            rem = num % {32'd0, dtim};
            if (quo >= 64'h1_0000)
                rpm_mag = 64'hFFFF_FFFF;
            else
                rpm_mag = (quo << 16) + ((rem << 16) / {32'd0, dtim});
        end
        cab_mag = (rpm_mag * {32'd0, cable_scale}) >> 32;
        net = count_offset + cnt;
        net_neg = net[31];
        net_mag = net_neg ? (~net + 32'd1) : net;
        dist_mag = ({32'd0, net_mag} * {32'd0, dist_scale}) >> 16;
        held_distance = clamp_signed(dist_mag, net_neg);
        w.speed_rpm = clamp_signed(rpm_mag, neg);
        w.cable_speed = clamp_signed(cab_mag, neg);
        w.cable_distance = held_distance;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, exp_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpm_scale = esd_pkg::RPM_FACTOR_RESET;
            cable_scale = esd_pkg::CABLE_SPEED_FACTOR_RESET;
            dist_scale = esd_pkg::DISTANCE_FACTOR_RESET;
            count_offset = esd_pkg::ZERO_OFFSET_RESET;
            for (int i = 0; i < CHANNELS; i++)
            begin
                chan_time[i] = 32'd0;
                chan_count[i] = 32'd0;
            end
            held_distance = 32'd0;
            speed_words_due.delete();
            mismatches = 0;
            results_seen = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    esd_pkg::REG_RPM_FACTOR:         rpm_scale = cfg.data;
                    esd_pkg::REG_CABLE_SPEED_FACTOR: cable_scale = cfg.data;
                    esd_pkg::REG_DISTANCE_FACTOR:    dist_scale = cfg.data;
                    esd_pkg::REG_ZERO_OFFSET:        count_offset = cfg.data;
                    default: ;
                endcase
            end
            if (samples.valid && samples.ready)
                speed_words_due.push_back(predict_speed(samples.requester,
                                                        samples.capture_time,
                                                        samples.encoder_count));
            if (results.valid && results.ready)
            begin
                results_seen++;
                if (speed_words_due.size() == 0)
                    report_mismatch("result word with nothing expected",
                                    results.speed_rpm, 32'd0);
                else
                begin
                    want = speed_words_due.pop_front();
                    if (results.speed_rpm !== want.speed_rpm)
                        report_mismatch("speed_rpm", results.speed_rpm, want.speed_rpm);
                    if (results.cable_speed !== want.cable_speed)
                        report_mismatch("cable_speed", results.cable_speed, want.cable_speed);
                    if (results.cable_distance !== want.cable_distance)
                        report_mismatch("cable_distance", results.cable_distance,
                                        want.cable_distance);
                    if (results.no_motion !== want.no_motion)
                        report_mismatch("no_motion", {31'd0, results.no_motion},
                                        {31'd0, want.no_motion});
                    if (results.div_error !== want.div_error)
                        report_mismatch("div_error", {31'd0, results.div_error},
                                        {31'd0, want.div_error});
                end
            end
            pending <= speed_words_due.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CHANNELS     = esd_pkg::NUM_REQUESTERS_DEFAULT;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned SETTLE       = 60;
    localparam int unsigned BATCHES      = 6;
    localparam int unsigned BATCH_WORDS  = 45;

    logic clk = 1'b0;
    logic rst_n;

    esd_sample_if samples_bus();
    esd_result_if results_bus();
    esd_cfg_if    cfg_bus();

    int unsigned mismatches;
    int unsigned pending;
    int unsigned results_seen;

    int unsigned send_idle_pct = 14;
    int unsigned take_idle_pct = 52;
    logic        holding = 1'b0;
    event        hold_results_ev;
    int unsigned cycles = 0;
    int unsigned samples_sent = 0;
    int unsigned cfg_writes = 0;

    logic [31:0] track_time  [CHANNELS];
    logic [31:0] track_count [CHANNELS];

    encoder_speed_and_distance dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_bus),
        .results (results_bus),
        .cfg     (cfg_bus)
    );

    esd_checker chk
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .samples      (samples_bus),
        .results      (results_bus),
        .cfg          (cfg_bus),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        results_bus.ready <= !holding && ($urandom_range(99) >= take_idle_pct);

    // hold off the result side so the block backs up into the sample side
    initial
    begin
        forever
        begin
            @(hold_results_ev);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding <= 1'b0;
        end
    end

    task automatic send_sample(input logic [esd_pkg::REQ_W-1:0] req, input logic [31:0] tim,
                               input logic [31:0] cnt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            samples_bus.valid <= 1'b0;
            @(posedge clk);
        end
        samples_bus.valid <= 1'b1;
        samples_bus.requester <= req;
        samples_bus.capture_time <= tim;
        samples_bus.encoder_count <= cnt;
        do @(posedge clk); while (!samples_bus.ready);
        samples_sent++;
        if (cnt != track_count[req])
        begin
            track_count[req] = cnt;
            track_time[req] = tim;
        end
    endtask

    // next sample of one channel: mostly a small count step and ordinary tick gap
    task automatic send_motion(input logic [esd_pkg::REQ_W-1:0] req);
        logic [31:0] dt;
        logic [31:0] dc;
        case ($urandom_range(19))
            0:       dt = 32'd0;
            1:       dt = $urandom;
            2:       dt = $urandom_range(16, 1);
            default: dt = $urandom_range(400000, 500);
        endcase
        case ($urandom_range(19))
            0:       dc = $urandom;
            1, 2:    dc = 32'd0;
            default: dc = 32'($urandom_range(6000)) - 32'd3000;
        endcase
        send_sample(req, track_time[req] + dt, track_count[req] + dc);
    endtask

    task automatic drain;
        samples_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic put_register(input esd_pkg::cfg_reg_t idx, input logic [31:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_writes++;
    endtask

    task automatic write_config(input logic [31:0] rpm, input logic [31:0] csf,
                                input logic [31:0] df, input logic [31:0] zo);
        put_register(esd_pkg::REG_RPM_FACTOR, rpm);
        put_register(esd_pkg::REG_CABLE_SPEED_FACTOR, csf);
        put_register(esd_pkg::REG_DISTANCE_FACTOR, df);
        put_register(esd_pkg::REG_ZERO_OFFSET, zo);
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_factor(input int unsigned typical_hi);
        logic [31:0] v;
        case ($urandom_range(7))
            0:       v = 32'd0;
            1:       v = 32'hFFFF_FFFF;
            2:       v = $urandom;
            default: v = $urandom_range(typical_hi, 1);
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_offset();
        logic [31:0] v;
        case ($urandom_range(7))
            0:       v = 32'd0;
            1:       v = 32'h8000_0000;
            2:       v = 32'h7FFF_FFFF;
            3:       v = $urandom;
            default: v = 32'($urandom_range(2000000)) - 32'd1000000;
        endcase
        return v;
    endfunction

    initial
    begin
        rst_n <= 1'b0;
        samples_bus.valid <= 1'b0;
        samples_bus.requester <= '0;
        samples_bus.capture_time <= '0;
        samples_bus.encoder_count <= '0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= esd_pkg::REG_RPM_FACTOR;
        cfg_bus.data <= '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            track_time[i] = 32'd0;
            track_count[i] = 32'd0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: no motion, moves both ways, zero tick gap, wraps
        send_sample(2'd0, 32'd5, 32'd0);
        send_sample(2'd0, 32'd84000, 32'd1000);
        send_sample(2'd0, 32'd90000, 32'd1000);
        send_sample(2'd0, 32'd168000, 32'd900);
        send_sample(2'd1, 32'd0, 32'd5);
        send_sample(2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(2'd1, 32'd2, 32'd3);
        send_sample(2'd2, 32'd1, 32'h8000_0000);
        send_sample(2'd2, 32'd3, 32'hFFFF_FFFF);
        send_sample(2'd3, 32'hFFFF_FFFF, 32'd1);
        send_sample(2'd3, 32'hFFFF_FFFF, 32'd2);
        send_sample(2'd3, 32'hFFFF_FFFF, 32'd1);
        drain();

        // all registers at their top: saturate speeds and distance both ways
        write_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_sample(2'd0, 32'd200000, 32'd1);
        send_sample(2'd0, 32'd200001, 32'd2);
        send_sample(2'd1, 32'h0000_1000, 32'd0);
        send_sample(2'd2, 32'h0000_0100, 32'h0000_0010);
        drain();

        // all registers at their bottom
        write_config(32'd0, 32'd0, 32'd0, 32'h8000_0000);
        send_sample(2'd0, 32'd300000, 32'd7);
        send_sample(2'd2, 32'd50, 32'd0);
        send_sample(2'd3, 32'd77, 32'h8000_0000);
        send_sample(2'd1, 32'd99, 32'h7FFF_FFFF);
        drain();

        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 14;
                    take_idle_pct = 52;
                end
                1:
                begin
                    send_idle_pct = 52;
                    take_idle_pct = 14;
                end
                default:
                begin
                    send_idle_pct = 0;
                    take_idle_pct = 0;
                end
            endcase
            for (int batch = 0; batch < BATCHES; batch++)
            begin
                if (batch == 0)
                    write_config(esd_pkg::RPM_FACTOR_RESET, esd_pkg::CABLE_SPEED_FACTOR_RESET,
                                 esd_pkg::DISTANCE_FACTOR_RESET, pick_offset());
                else
                    write_config(pick_factor(20000000), pick_factor(32'h1000_0000),
                                 pick_factor(32'h0100_0000), pick_offset());
                for (int n = 0; n < BATCH_WORDS; n++)
                begin
                    if (batch == 2 && n == 5)
                        -> hold_results_ev;
                    if ($urandom_range(9) < 8)
                        send_motion(2'($urandom_range(CHANNELS - 1)));
                    else
                        send_sample(2'($urandom_range(3)), $urandom, $urandom);
                end
                drain();
            end
        end

        repeat (SETTLE) @(posedge clk);
        $display("Covered %0d samples over %0d channels, %0d results compared, %0d register writes,",
                 samples_sent, CHANNELS, results_seen, cfg_writes);
        $display("under three idle profiles with long result stalls and drained pauses.");
        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
